// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file mee_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define MEE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define MEE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

`endif

// ----- hw/rtl/mee_pkg.sv -----
// types and constants of the exception entry block
package mee_pkg;

  localparam logic [1:0] OpRaise     = 2'd0;
  localparam logic [1:0] OpInterrupt = 2'd1;
  localparam logic [1:0] OpCop0Check = 2'd2;
  localparam logic [1:0] OpOverflow  = 2'd3;

  localparam logic [1:0] CfgVectorBaseNormal = 2'd0;
  localparam logic [1:0] CfgVectorBaseBoot   = 2'd1;
  localparam logic [1:0] CfgCommonOffset     = 2'd2;
  localparam logic [1:0] CfgRefillOffset     = 2'd3;

  localparam logic [4:0] CodeInterrupt    = 5'd0;
  localparam logic [4:0] CodeCpuUnusable  = 5'd11;
  localparam logic [4:0] CodeOverflow     = 5'd12;

  localparam logic [31:0] ResetBaseNormal   = 32'h8000_0000;
  localparam logic [31:0] ResetBaseBoot     = 32'hBFC0_0000;
  localparam logic [11:0] ResetCommonOffset = 12'h080;
  localparam logic [11:0] ResetRefillOffset = 12'h000;

  localparam logic [31:0] PcStep = 32'd4;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        current_pc;
    logic               branch_pending;
    logic [4:0]         exc_code;
    logic               is_refill;
    logic [5:0]         status_stack;
    logic [7:0]         int_mask;
    logic [7:0]         int_pending;
    logic               boot_vectors;
    logic               cop0_usable;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic        taken;
    logic [31:0] next_pc;
    logic [31:0] exception_pc;
    logic        delay_slot_flag;
    logic [4:0]  cause_code;
    logic        clear_ce;
    logic [5:0]  status_stack_out;
  } rsp_t;

  typedef struct packed {
    logic [31:0] vector_base_normal;
    logic [31:0] vector_base_boot;
    logic [11:0] common_offset;
    logic [11:0] refill_offset;
  } cfg_t;

endpackage

// ----- hw/rtl/mee_cfg_regs.sv -----
// vector base and offset configuration registers
module mee_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i,
  output mee_pkg::cfg_t    cfg_o
);

  mee_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_i) begin
      case (cfg_index_i)
        mee_pkg::CfgVectorBaseNormal: cfg_d.vector_base_normal = cfg_data_i;
        mee_pkg::CfgVectorBaseBoot:   cfg_d.vector_base_boot   = cfg_data_i;
        mee_pkg::CfgCommonOffset:     cfg_d.common_offset      = cfg_data_i[11:0];
        mee_pkg::CfgRefillOffset:     cfg_d.refill_offset      = cfg_data_i[11:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vector_base_normal <= mee_pkg::ResetBaseNormal;
      cfg_q.vector_base_boot   <= mee_pkg::ResetBaseBoot;
      cfg_q.common_offset      <= mee_pkg::ResetCommonOffset;
      cfg_q.refill_offset      <= mee_pkg::ResetRefillOffset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/mee_eval.sv -----
// exception decision, vector, epc and status push for one request
module mee_eval (
  input  mee_pkg::req_t req_i,
  input  mee_pkg::cfg_t cfg_i,
  output mee_pkg::rsp_t rsp_o
);

  logic        take;
  logic        use_refill;
  logic [4:0]  code;
  logic        ce;
  logic [31:0] sum;
  logic        ovf;
  logic [31:0] base;
  logic [11:0] offset;
  logic [31:0] vector;

  assign sum = req_i.operand_a + req_i.operand_b;
  assign ovf = ((req_i.operand_a[31] ^ sum[31]) & (req_i.operand_b[31] ^ sum[31]));

  always_comb begin
    take       = 1'b0;
    use_refill = 1'b0;
    code       = mee_pkg::CodeInterrupt;
    ce         = 1'b0;
    case (req_i.opcode)
      mee_pkg::OpRaise: begin
        take       = 1'b1;
        code       = req_i.exc_code;
        use_refill = req_i.is_refill;
      end
      mee_pkg::OpInterrupt: begin
        take = req_i.status_stack[0] && ((req_i.int_pending & req_i.int_mask) != 8'd0);
        code = mee_pkg::CodeInterrupt;
      end
      mee_pkg::OpCop0Check: begin
        take = !req_i.cop0_usable;
        code = mee_pkg::CodeCpuUnusable;
        ce   = 1'b1;
      end
      mee_pkg::OpOverflow: begin
        take = ovf;
        code = mee_pkg::CodeOverflow;
      end
      default: take = 1'b0;
    endcase
  end

  assign base   = req_i.boot_vectors ? cfg_i.vector_base_boot : cfg_i.vector_base_normal;
  assign offset = use_refill ? cfg_i.refill_offset : cfg_i.common_offset;
  assign vector = base + {20'd0, offset};

  always_comb begin
    if (take) begin
      rsp_o.taken            = 1'b1;
      rsp_o.next_pc          = vector;
      rsp_o.exception_pc     = req_i.branch_pending ? (req_i.current_pc - mee_pkg::PcStep)
                                                    : req_i.current_pc;
      rsp_o.delay_slot_flag  = req_i.branch_pending;
      rsp_o.cause_code       = code;
      rsp_o.clear_ce         = ce;
      rsp_o.status_stack_out = {req_i.status_stack[3:0], 2'b00};
    end else begin
      rsp_o.taken            = 1'b0;
      rsp_o.next_pc          = req_i.current_pc;
      rsp_o.exception_pc     = 32'd0;
      rsp_o.delay_slot_flag  = 1'b0;
      rsp_o.cause_code       = 5'd0;
      rsp_o.clear_ce         = 1'b0;
      rsp_o.status_stack_out = req_i.status_stack;
    end
  end

endmodule

// ----- hw/rtl/mips_exception_entry.sv -----
// top level of the exception entry block
//
//  channel | direction | handshake              | payload
//  in      | request   | in_valid_i / in_stall_o | in_req_i   (mee_pkg::req_t)
//  out     | response  | out_valid_o / out_stall_i | out_rsp_o (mee_pkg::rsp_t)
//  cfg     | write     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  one request per cycle while in_stall_o is low; an accepted request goes to the input
//  register, then is evaluated into the response register
//  reset clears both valid flags and loads the default vector bases and offsets
//  a stalled response holds; the input stalls only when both registers are full
//  and the response is stalled
module mips_exception_entry (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mee_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mee_pkg::rsp_t out_rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  mee_pkg::cfg_t cfg;
  mee_pkg::req_t req_q;
  mee_pkg::rsp_t rsp_d, rsp_q;
  logic          req_valid_q, req_valid_d;
  logic          rsp_valid_q, rsp_valid_d;
  logic          rsp_free;
  logic          in_take;

  assign cfg_ready_o = 1'b1;

  mee_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mee_eval u_eval (
    .req_i (req_q),
    .cfg_i (cfg),
    .rsp_o (rsp_d)
  );

  assign rsp_free   = !rsp_valid_q || !out_stall_i;
  assign in_stall_o = req_valid_q && !rsp_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    req_valid_d = req_valid_q;
    if (in_take) begin
      req_valid_d = 1'b1;
    end else if (rsp_free) begin
      req_valid_d = 1'b0;
    end
    rsp_valid_d = rsp_free ? req_valid_q : rsp_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= in_req_i;
    end
    if (rsp_free && req_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ----- hw/rtl/mee_checker.sv -----
// port-level checks of the exception entry block and their binding
`include "assert_macros.svh"

module mee_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input mee_pkg::rsp_t out_rsp_o
);

  `MEE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o))
  `MEE_ASSERT_IMPL(a_idle_fields_zero, out_valid_o && !out_rsp_o.taken, (out_rsp_o.exception_pc == 32'd0) && (out_rsp_o.cause_code == 5'd0) && !out_rsp_o.clear_ce && !out_rsp_o.delay_slot_flag)
  `MEE_ASSERT_IMPL(a_ce_is_cpu, out_valid_o && out_rsp_o.clear_ce, out_rsp_o.taken && (out_rsp_o.cause_code == mee_pkg::CodeCpuUnusable))
  `MEE_ASSERT_IMPL(a_stack_pushed, out_valid_o && out_rsp_o.taken, out_rsp_o.status_stack_out[1:0] == 2'b00)

endmodule

bind mips_exception_entry mee_checker u_mee_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

// ----- verif/mips_exception_entry_test.sv -----
// testbench of the exception entry block: directed table, then random requests under config phases
`timescale 1ns / 100ps

module mips_exception_entry_test;

  localparam int CycleLimit = 100000;
  localparam int RandomPerPhase = 175;
  localparam int PhaseCount = 6;
  localparam int HoldCycles = 80;

  typedef struct {
    mee_pkg::req_t req;
    bit            known;
    mee_pkg::rsp_t want;
  } entry_case_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  mee_pkg::req_t in_req_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  mee_pkg::rsp_t out_rsp_o;
  logic  cfg_valid_i = 1'b0;
  logic  cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  mee_pkg::cfg_t vector_cfg;
  mee_pkg::rsp_t pending_entries[$];
  entry_case_t   directed_cases[$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;
  bit          hold_trigger = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;

  mips_exception_entry u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("mips_exception_entry_test: errors");
      $finish;
    end
  end

  function automatic mee_pkg::rsp_t predict_entry(mee_pkg::req_t r);
    mee_pkg::rsp_t res;
    logic        take;
    logic        use_refill;
    logic [4:0]  code;
    logic        ce;
    logic [31:0] sum;
    logic [31:0] base;
    logic [31:0] offset;
    take = 1'b0;
    use_refill = 1'b0;
    code = mee_pkg::CodeInterrupt;
    ce = 1'b0;
    sum = r.operand_a + r.operand_b;
    case (r.opcode)
      mee_pkg::OpRaise: begin
        take = 1'b1;
        code = r.exc_code;
        use_refill = r.is_refill;
      end
      mee_pkg::OpInterrupt: begin
        if (r.status_stack[0] && (r.int_pending & r.int_mask) != 8'h00) begin
          take = 1'b1;
          code = mee_pkg::CodeInterrupt;
        end
      end
      mee_pkg::OpCop0Check: begin
        if (!r.cop0_usable) begin
          take = 1'b1;
          code = mee_pkg::CodeCpuUnusable;
          ce = 1'b1;
        end
      end
      default: begin
        if (r.operand_a[31] == r.operand_b[31] && sum[31] != r.operand_a[31]) begin
          take = 1'b1;
          code = mee_pkg::CodeOverflow;
        end
      end
    endcase
    if (take) begin
      base = r.boot_vectors ? vector_cfg.vector_base_boot : vector_cfg.vector_base_normal;
      offset = {20'd0, use_refill ? vector_cfg.refill_offset : vector_cfg.common_offset};
      res.taken = 1'b1;
      res.next_pc = base + offset;
      res.exception_pc = r.branch_pending ? r.current_pc - mee_pkg::PcStep : r.current_pc;
      res.delay_slot_flag = r.branch_pending;
      res.cause_code = code;
      res.clear_ce = ce;
      res.status_stack_out = {r.status_stack[3:0], 2'b00};
    end else begin
      res = '0;
      res.next_pc = r.current_pc;
      res.status_stack_out = r.status_stack;
    end
    return res;
  endfunction

  function automatic mee_pkg::req_t make_req(logic [1:0] op, logic [31:0] pc, logic bd,
                                             logic [4:0] exc, logic refill,
                                             logic [5:0] stack, logic [7:0] im,
                                             logic [7:0] ip, logic bev, logic usable,
                                             logic [31:0] a, logic [31:0] b);
    mee_pkg::req_t r;
    r.opcode = op;
    r.current_pc = pc;
    r.branch_pending = bd;
    r.exc_code = exc;
    r.is_refill = refill;
    r.status_stack = stack;
    r.int_mask = im;
    r.int_pending = ip;
    r.boot_vectors = bev;
    r.cop0_usable = usable;
    r.operand_a = a;
    r.operand_b = b;
    return r;
  endfunction

  function automatic mee_pkg::rsp_t make_rsp(logic taken, logic [31:0] npc,
                                             logic [31:0] epc, logic bd, logic [4:0] code,
                                             logic ce, logic [5:0] stack);
    mee_pkg::rsp_t w;
    w.taken = taken;
    w.next_pc = npc;
    w.exception_pc = epc;
    w.delay_slot_flag = bd;
    w.cause_code = code;
    w.clear_ce = ce;
    w.status_stack_out = stack;
    return w;
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000 + $urandom_range(7);
      1: return 32'hFFFF_FFFF - $urandom_range(7);
      2: return 32'h7FFF_FFFF - $urandom_range(3);
      3: return 32'h8000_0000 + $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  function automatic mee_pkg::req_t random_request();
    mee_pkg::req_t r;
    r.opcode = 2'($urandom_range(3));
    r.current_pc = random_word();
    r.branch_pending = 1'($urandom_range(1));
    r.exc_code = 5'($urandom_range(31));
    r.is_refill = 1'($urandom_range(1));
    r.status_stack = 6'($urandom_range(63));
    r.int_mask = 8'($urandom_range(255));
    r.int_pending = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
    r.boot_vectors = 1'($urandom_range(1));
    r.cop0_usable = 1'($urandom_range(1));
    r.operand_a = random_word();
    r.operand_b = random_word();
    return r;
  endfunction

  task automatic add_case(mee_pkg::req_t r, bit known, mee_pkg::rsp_t w);
    entry_case_t c;
    c.req = r;
    c.known = known;
    c.want = w;
    directed_cases.push_back(c);
  endtask

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
    end
  endtask

  task automatic check_entry(mee_pkg::rsp_t got);
    mee_pkg::rsp_t want;
    if (pending_entries.size() == 0) begin
      error_count++;
      $display("%0t: response with nothing expected, got %0h", $time, got);
    end else begin
      want = pending_entries.pop_front();
      compare_field("taken", want.taken, got.taken);
      compare_field("next_pc", want.next_pc, got.next_pc);
      compare_field("exception_pc", want.exception_pc, got.exception_pc);
      compare_field("delay_slot_flag", want.delay_slot_flag, got.delay_slot_flag);
      compare_field("cause_code", want.cause_code, got.cause_code);
      compare_field("clear_ce", want.clear_ce, got.clear_ce);
      compare_field("status_stack_out", want.status_stack_out, got.status_stack_out);
    end
  endtask

  // response side: check, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_entry(out_rsp_o);
    end
    if (hold_trigger && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 16);
    end
  end

  task automatic send_request(mee_pkg::req_t r, bit known, mee_pkg::rsp_t want);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    pending_entries.push_back(known ? want : predict_entry(r));
  endtask

  task automatic drain_entries();
    in_valid_i <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(logic [1:0] index, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_vectors(mee_pkg::cfg_t c);
    write_register(mee_pkg::CfgVectorBaseNormal, c.vector_base_normal);
    write_register(mee_pkg::CfgVectorBaseBoot, c.vector_base_boot);
    write_register(mee_pkg::CfgCommonOffset, {20'd0, c.common_offset});
    write_register(mee_pkg::CfgRefillOffset, {20'd0, c.refill_offset});
    cfg_valid_i <= 1'b0;
    vector_cfg = c;
  endtask

  initial begin
    mee_pkg::cfg_t next_cfg;
    mee_pkg::rsp_t none;
    none = '0;
    vector_cfg.vector_base_normal = mee_pkg::ResetBaseNormal;
    vector_cfg.vector_base_boot = mee_pkg::ResetBaseBoot;
    vector_cfg.common_offset = mee_pkg::ResetCommonOffset;
    vector_cfg.refill_offset = mee_pkg::ResetRefillOffset;

    add_case(make_req(mee_pkg::OpRaise, 32'h0000_1000, 0, 31, 0, 6'h3F, 8'h00, 8'h00, 0, 1,
                      0, 0),
             1, make_rsp(1, 32'h8000_0080, 32'h0000_1000, 0, 5'd31, 0, 6'h3C));
    add_case(make_req(mee_pkg::OpRaise, 32'h0000_0000, 1, 0, 1, 6'h00, 8'h00, 8'h00, 1, 1,
                      0, 0),
             1, make_rsp(1, 32'hBFC0_0000, 32'hFFFF_FFFC, 1, 5'd0, 0, 6'h00));
    add_case(make_req(mee_pkg::OpRaise, 32'hFFFF_FFFF, 0, 1, 1, 6'h15, 8'hFF, 8'hFF, 0, 0,
                      0, 0),
             1, make_rsp(1, 32'h8000_0000, 32'hFFFF_FFFF, 0, 5'd1, 0, 6'h14));
    add_case(make_req(mee_pkg::OpInterrupt, 32'hFFFF_FFFF, 0, 0, 0, 6'h01, 8'h80, 8'h80,
                      0, 1, 0, 0),
             1, make_rsp(1, 32'h8000_0080, 32'hFFFF_FFFF, 0, mee_pkg::CodeInterrupt, 0,
                         6'h04));
    add_case(make_req(mee_pkg::OpInterrupt, 32'h0000_0100, 0, 0, 0, 6'h3E, 8'hFF, 8'hFF,
                      0, 1, 0, 0),
             1, make_rsp(0, 32'h0000_0100, 0, 0, mee_pkg::CodeInterrupt, 0, 6'h3E));
    add_case(make_req(mee_pkg::OpInterrupt, 32'h0000_0200, 0, 0, 0, 6'h01, 8'h0F, 8'hF0,
                      0, 1, 0, 0),
             1, make_rsp(0, 32'h0000_0200, 0, 0, mee_pkg::CodeInterrupt, 0, 6'h01));
    add_case(make_req(mee_pkg::OpInterrupt, 32'h0000_0008, 1, 0, 1, 6'h3F, 8'h01, 8'h01,
                      1, 1, 0, 0),
             1, make_rsp(1, 32'hBFC0_0080, 32'h0000_0004, 1, mee_pkg::CodeInterrupt, 0,
                         6'h3C));
    add_case(make_req(mee_pkg::OpCop0Check, 32'h0000_0004, 1, 0, 0, 6'h2A, 8'h00, 8'h00,
                      0, 0, 0, 0),
             1, make_rsp(1, 32'h8000_0080, 32'h0000_0000, 1, mee_pkg::CodeCpuUnusable, 1,
                         6'h28));
    add_case(make_req(mee_pkg::OpCop0Check, 32'hDEAD_BEEC, 0, 0, 0, 6'h2A, 8'h00, 8'h00,
                      0, 1, 0, 0),
             1, make_rsp(0, 32'hDEAD_BEEC, 0, 0, mee_pkg::CodeInterrupt, 0, 6'h2A));
    add_case(make_req(mee_pkg::OpOverflow, 32'h0000_0040, 0, 0, 0, 6'h00, 8'h00, 8'h00,
                      0, 1, 32'h7FFF_FFFF, 32'h0000_0001),
             1, make_rsp(1, 32'h8000_0080, 32'h0000_0040, 0, mee_pkg::CodeOverflow, 0,
                         6'h00));
    add_case(make_req(mee_pkg::OpOverflow, 32'h0000_0044, 0, 0, 1, 6'h03, 8'h00, 8'h00,
                      1, 1, 32'h8000_0000, 32'h8000_0000),
             1, make_rsp(1, 32'hBFC0_0080, 32'h0000_0044, 0, mee_pkg::CodeOverflow, 0,
                         6'h0C));
    add_case(make_req(mee_pkg::OpOverflow, 32'h0000_0048, 0, 0, 0, 6'h03, 8'h00, 8'h00,
                      0, 1, 32'h7FFF_FFFF, 32'h8000_0000),
             1, make_rsp(0, 32'h0000_0048, 0, 0, mee_pkg::CodeInterrupt, 0, 6'h03));
    add_case(make_req(mee_pkg::OpOverflow, 32'h0000_004C, 1, 0, 0, 6'h03, 8'h00, 8'h00,
                      0, 1, 32'hFFFF_FFFF, 32'h0000_0001),
             1, make_rsp(0, 32'h0000_004C, 0, 0, mee_pkg::CodeInterrupt, 0, 6'h03));
    add_case(make_req(mee_pkg::OpOverflow, 32'h1234_5678, 1, 31, 1, 6'h3F, 8'hFF, 8'hFF,
                      1, 0, 32'h8000_0000, 32'hFFFF_FFFF), 0, none);
    add_case(make_req(mee_pkg::OpRaise, 32'h0000_0004, 1, 11, 0, 6'h3F, 8'hFF, 8'hFF,
                      1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0, none);
    add_case(make_req(mee_pkg::OpCop0Check, 32'hFFFF_FFF8, 0, 31, 1, 6'h3F, 8'hFF, 8'hFF,
                      1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0, none);
    add_case(make_req(mee_pkg::OpInterrupt, 32'h8000_0000, 1, 31, 1, 6'h01, 8'hFF, 8'h01,
                      0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0, none);

    wait (rst_ni);
    @(posedge clk_i);

    foreach (directed_cases[i]) begin
      send_request(directed_cases[i].req, directed_cases[i].known, directed_cases[i].want);
    end

    for (int phase = 0; phase < PhaseCount; phase++) begin
      drain_entries();
      case (phase)
        0: next_cfg = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF};
        1: next_cfg = '{32'h0000_0000, 32'h0000_0000, 12'h000, 12'h000};
        default: begin
          next_cfg.vector_base_normal = random_word();
          next_cfg.vector_base_boot = random_word();
          next_cfg.common_offset = 12'($urandom_range(4095));
          next_cfg.refill_offset = 12'($urandom_range(4095));
        end
      endcase
      load_vectors(next_cfg);
      for (int n = 0; n < RandomPerPhase; n++) begin
        calm = (phase == 2) && (n >= 40) && (n < 120);
        hold_trigger = hold_trigger || ((phase == 0) && (n == 20));
        send_request(random_request(), 0, none);
      end
      calm = 1'b0;
    end

    drain_entries();
    if (error_count == 0) begin
      $display("mips_exception_entry_test: clean");
    end else begin
      $display("mips_exception_entry_test: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/mee_pkg.sv
hw/rtl/mee_cfg_regs.sv
hw/rtl/mee_eval.sv
hw/rtl/mips_exception_entry.sv
hw/rtl/mee_checker.sv
verif/mips_exception_entry_test.sv
